/* design/assert_macros.svh */
// Assertion macros used by the scanner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MBPS_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define MBPS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* design/mbps_pkg.sv */
// Types, constants and helper functions of the masked byte pattern scanner.
package mbps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int OFFSET_BITS = 32;
	localparam int ADDR_W = 48;
	localparam int DATA_W = 64;
	localparam int PLEN_W = 5;
	localparam int CARE_W = 16;
	localparam int PAT_BYTES = 16;
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int PSEL_W = (LEN_W > 4) ? LEN_W : 4;
	localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LOW    = 3'd0,
		CFG_PATTERN_HIGH   = 3'd1,
		CFG_CARE_MASK      = 3'd2,
		CFG_PATTERN_LENGTH = 3'd3,
		CFG_BASE_ADDRESS   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

	// Result handed from the scan logic to the output pipe.
	typedef struct packed {
		logic                   found;
		logic [OFFSET_BITS-1:0] offset;
	} scan_res_t;

	// Clamp the programmed length into 1..MAX_PATTERN.
	function automatic logic [LEN_W-1:0] eff_length(input logic [PLEN_W-1:0] raw);
		logic [LEN_W-1:0] n;
		if (raw == '0)
			n = LEN_W'(1);
		else if (int'(raw) > MAX_PATTERN)
			n = LEN_W'(MAX_PATTERN);
		else
			n = LEN_W'(raw);
		return n;
	endfunction

	// Pattern byte at position p; positions past the registers read as zero.
	function automatic logic [7:0] pat_byte(input logic [2*DATA_W-1:0] pat,
			input logic [LEN_W-1:0] p);
		logic [PSEL_W-1:0] pe;
		logic [7:0] b;
		pe = PSEL_W'(p);
		if (int'(pe) < PAT_BYTES)
			b = pat[8*pe[3:0] +: 8];
		else
			b = 8'h00;
		return b;
	endfunction

	// Care bit at position p; positions past the registers are wildcards.
	function automatic logic pat_care(input logic [CARE_W-1:0] care,
			input logic [LEN_W-1:0] p);
		logic [PSEL_W-1:0] pe;
		logic c;
		pe = PSEL_W'(p);
		if (int'(pe) < PAT_BYTES)
			c = care[pe[3:0]];
		else
			c = 1'b0;
		return c;
	endfunction

endpackage

/* design/mbps_cell.sv */
// One window cell: holds one byte, passes it on, and compares the byte it takes.
module mbps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic [7:0] din,
	input  logic [7:0] exp_byte,
	input  logic       care,
	output logic [7:0] dout,
	output logic       hit
);
	import mbps_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (shift_en) begin
			byte_q <= din;
		end
	end

	// Compare the byte this cell holds after the shift.
	assign hit = !care || (din == exp_byte);
	assign dout = byte_q;

endmodule

/* design/mbps_out.sv */
// Result pipe: offset stage, then address add into the output register.
module mbps_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  mbps_pkg::scan_res_t       res,
	input  logic [mbps_pkg::ADDR_W-1:0] base,
	output logic                      can_push,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mbps_pkg::out_item_t       out_item
);
	import mbps_pkg::*;

	logic      v_s1;
	scan_res_t res_s1;
	logic      v_s2;
	out_item_t item_s2;
	logic      s2_free;
	logic      move;

	assign s2_free = !v_s2 || out_ready;
	assign move = v_s1 && s2_free;
	assign can_push = !v_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (push)
				v_s1 <= 1'b1;
			else if (move)
				v_s1 <= 1'b0;
			if (move)
				v_s2 <= 1'b1;
			else if (out_ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			res_s1 <= res;
		if (move) begin
			item_s2.found <= res_s1.found;
			item_s2.match_address <= res_s1.found ? base + ADDR_W'(res_s1.offset) : '0;
		end
	end

	assign out_valid = v_s2;
	assign out_item = item_s2;

endmodule

/* design/masked_byte_pattern_scanner_unit.sv */
// Top level of the masked byte pattern scanner: config, window chain, result pipe.
//
// channel  direction  handshake          payload
// in       input      in_valid/in_ready   in_item_t (data_byte, first_byte, last_byte)
// out      output     out_valid/out_ready out_item_t (found, match_address)
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; the whole window is compared in
// the cycle the byte is taken. Results pass the offset stage, then the address add.
// in_ready drops only when both result stages are full and out is stalled.
// Reset clears the window, counter, done flag and result pipe; registers get defaults.
// cfg is always ready; a write takes effect for the next byte.
module masked_byte_pattern_scanner_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mbps_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mbps_pkg::out_item_t           out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbps_pkg::DATA_W-1:0]   cfg_data
);
	import mbps_pkg::*;

	logic [DATA_W-1:0]      pattern_low_q;
	logic [DATA_W-1:0]      pattern_high_q;
	logic [CARE_W-1:0]      care_mask_q;
	logic [PLEN_W-1:0]      pattern_length_q;
	logic [ADDR_W-1:0]      base_address_q;
	logic [OFFSET_BITS-1:0] count_q;
	logic                   done_q;

	logic                   in_fire;
	logic                   cfg_fire;
	logic                   active;
	logic [OFFSET_BITS-1:0] count_base;
	logic [OFFSET_BITS-1:0] count_new;
	logic                   done_base;
	logic [LEN_W-1:0]       len_eff;
	logic [LEN_W-1:0]       len_m1;
	logic [2*DATA_W-1:0]    pattern;
	logic [MAX_PATTERN-1:0] cell_hit;
	logic [7:0]             win [MAX_PATTERN];
	logic                   all_hit;
	logic                   hit;
	logic                   res_push;
	logic                   can_push;
	scan_res_t              res;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_ready = can_push;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q <= '0;
			pattern_high_q <= '0;
			care_mask_q <= '1;
			pattern_length_q <= PLEN_W'(1);
			base_address_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_LOW:    pattern_low_q <= cfg_data;
				CFG_PATTERN_HIGH:   pattern_high_q <= cfg_data;
				CFG_CARE_MASK:      care_mask_q <= cfg_data[CARE_W-1:0];
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[PLEN_W-1:0];
				CFG_BASE_ADDRESS:   base_address_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// A first byte restarts the region before the byte is taken.
	assign count_base = in_item.first_byte ? '0 : count_q;
	assign done_base = in_item.first_byte ? 1'b0 : done_q;
	assign active = in_fire && !done_base;
	assign count_new = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;

	assign len_eff = eff_length(pattern_length_q);
	assign len_m1 = len_eff - 1'b1;
	assign pattern = {pattern_high_q, pattern_low_q};

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [7:0]       din;
		logic [LEN_W-1:0] pos;
		logic             in_use;

		// Cell k holds the byte taken k steps ago; it meets pattern byte len-1-k.
		assign pos = len_m1 - LEN_W'(k);
		assign in_use = int'(len_eff) > k;
		if (k == 0) begin : g_head
			assign din = in_item.data_byte;
		end else begin : g_link
			assign din = win[k-1];
		end

		mbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (active),
			.din      (din),
			.exp_byte (pat_byte(pattern, pos)),
			.care     (in_use && pat_care(care_mask_q, pos)),
			.dout     (win[k]),
			.hit      (cell_hit[k])
		);
	end

	assign all_hit = &cell_hit;
	assign hit = all_hit && (count_new >= OFFSET_BITS'(len_eff));
	assign res_push = active && (hit || in_item.last_byte);
	assign res.found = hit;
	assign res.offset = hit ? count_new - OFFSET_BITS'(len_eff) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
		end else if (in_fire) begin
			count_q <= active ? count_new : count_base;
			done_q <= done_base || res_push;
		end
	end

	mbps_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.res       (res),
		.base      (base_address_q),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	`include "assert_macros.svh"

	`MBPS_ASSERT_NEXT(a_done_after_result, res_push, done_q, "search not closed after result")
	`MBPS_ASSERT_IMPL(a_miss_zero_addr, out_valid && !out_item.found, out_item.match_address == '0, "not-found item carries an address")
	`MBPS_ASSERT_IMPL(a_stall_only_on_out, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

endmodule

/* tb/tb_masked_byte_pattern_scanner_unit.sv */
// Testbench for the masked byte pattern scanner: directed and random regions under idling.
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scanner_unit;
	import mbps_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_ITEMS = 600;
	localparam int QUIET_ITEMS = 120;
	localparam int HOLD_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(7);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	// scanner state as the predictor sees it
	logic [DATA_W-1:0] m_pat_lo;
	logic [DATA_W-1:0] m_pat_hi;
	logic [CARE_W-1:0] m_care;
	logic [PLEN_W-1:0] m_plen;
	logic [ADDR_W-1:0] m_base;
	logic [7:0] m_window [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] m_count;
	logic m_done;

	out_item_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int rx_hold_len = 0;
	bit tx_idle_en;
	bit rx_idle_en;

	masked_byte_pattern_scanner_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic scan_model_reset();
		m_pat_lo = '0;
		m_pat_hi = '0;
		m_care = '1;
		m_plen = PLEN_W'(1);
		m_base = '0;
		foreach (m_window[k])
			m_window[k] = '0;
		m_count = '0;
		m_done = 1'b0;
	endtask

	task automatic scan_model_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		case (idx)
			CFG_PATTERN_LOW: m_pat_lo = val;
			CFG_PATTERN_HIGH: m_pat_hi = val;
			CFG_CARE_MASK: m_care = val[CARE_W-1:0];
			CFG_PATTERN_LENGTH: m_plen = val[PLEN_W-1:0];
			CFG_BASE_ADDRESS: m_base = val[ADDR_W-1:0];
			default: ;
		endcase
	endtask

	function automatic int active_length();
		if (m_plen == '0)
			return 1;
		if (m_plen > MAX_PATTERN)
			return MAX_PATTERN;
		return int'(m_plen);
	endfunction

	// Advance the window by one byte and queue the result it causes, if any.
	task automatic scan_model_step(input in_item_t it);
		int n;
		bit hit;
		logic [2*DATA_W-1:0] pat;
		out_item_t r;
		if (it.first_byte) begin
			m_count = '0;
			m_done = 1'b0;
		end
		if (m_done)
			return;
		for (int k = MAX_PATTERN - 1; k > 0; k--)
			m_window[k] = m_window[k-1];
		m_window[0] = it.data_byte;
		if (m_count != COUNT_MAX)
			m_count++;
		n = active_length();
		pat = {m_pat_hi, m_pat_lo};
		hit = (m_count >= n);
		for (int j = 0; j < n; j++)
			if (m_care[j] && pat[8*j +: 8] != m_window[n-1-j])
				hit = 1'b0;
		if (hit) begin
			r.found = 1'b1;
			r.match_address = m_base + ADDR_W'(m_count - OFFSET_BITS'(n));
			pending_results = {pending_results, r};
			m_done = 1'b1;
		end else if (it.last_byte) begin
			r.found = 1'b0;
			r.match_address = '0;
			pending_results = {pending_results, r};
			m_done = 1'b1;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
		in_item_t it;
		it.data_byte = b;
		it.first_byte = f;
		it.last_byte = l;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		scan_model_step(it);
		items_sent++;
	endtask

	// Drop valid, let every expected result arrive, then let the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_scanner(input logic [DATA_W-1:0] pl, input logic [DATA_W-1:0] ph,
			input logic [CARE_W-1:0] cm, input logic [PLEN_W-1:0] len,
			input logic [ADDR_W-1:0] base);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [DATA_W-1:0] val [6];
		int n;
		idx[0] = CFG_PATTERN_LOW;
		val[0] = pl;
		idx[1] = CFG_PATTERN_HIGH;
		val[1] = ph;
		// fill unused upper bits with junk, the block must drop them
		idx[2] = CFG_CARE_MASK;
		val[2] = {16'($urandom), 32'($urandom), cm};
		idx[3] = CFG_PATTERN_LENGTH;
		val[3] = {27'($urandom), 32'($urandom), len};
		idx[4] = CFG_BASE_ADDRESS;
		val[4] = {16'($urandom), base};
		idx[5] = CFG_SPARE_IDX;
		val[5] = {$urandom, $urandom};
		n = ($urandom_range(0, 3) == 0) ? 6 : 5;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			scan_model_write(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic program_random();
		logic [CARE_W-1:0] cm;
		logic [PLEN_W-1:0] len;
		logic [ADDR_W-1:0] base;
		int pick;
		case ($urandom_range(0, 3))
			0: cm = '1;
			1: cm = '0;
			default: cm = CARE_W'($urandom);
		endcase
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = '0;
		else if (pick == 1)
			len = PLEN_W'($urandom_range(MAX_PATTERN + 1, 31));
		else if (pick < 4)
			len = PLEN_W'(MAX_PATTERN);
		else
			len = PLEN_W'($urandom_range(1, 6));
		base = ($urandom_range(0, 9) == 0) ? '1 : {16'($urandom), 32'($urandom)};
		program_scanner({$urandom, $urandom}, {$urandom, $urandom}, cm, len, base);
	endtask

	// One region of random bytes, optionally with the pattern planted inside.
	task automatic scan_region(input bit embed, input bit drop_first, input bit drop_last,
			input bit noisy);
		int n;
		int rlen;
		int at;
		logic [7:0] region_bytes [$];
		logic [2*DATA_W-1:0] pat;
		logic f;
		logic l;
		n = active_length();
		pat = {m_pat_hi, m_pat_lo};
		rlen = $urandom_range(1, 20);
		if (embed && rlen < n)
			rlen = n + $urandom_range(0, 4);
		for (int i = 0; i < rlen; i++)
			region_bytes = {region_bytes, 8'($urandom)};
		if (embed) begin
			at = $urandom_range(0, rlen - n);
			for (int j = 0; j < n; j++)
				if (m_care[j])
					region_bytes[at+j] = pat[8*j +: 8];
		end
		for (int i = 0; i < rlen; i++) begin
			f = (i == 0) && !drop_first;
			l = (i == rlen - 1) && !drop_last;
			if (noisy) begin
				f = f | ($urandom_range(0, 7) == 0);
				l = l | ($urandom_range(0, 7) == 0);
			end
			send_byte(region_bytes[i], f, l);
		end
	endtask

	task automatic test_reset_values();
		// region opens at reset; defaults search for a single zero byte
		send_byte(8'h55, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_directed_cases();
		// length zero acts as one, match on the final byte, address wraps
		wait_idle();
		program_scanner('1, '1, '1, '0, '1);
		send_byte(8'h12, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		// oversized length clamps to full window, all positions wildcard
		wait_idle();
		program_scanner('0, '0, '0, PLEN_W'(31), '0);
		for (int i = 0; i < MAX_PATTERN; i++)
			send_byte((i % 2) ? 8'hFF : 8'h00, i == 0, i == MAX_PATTERN - 1);
	endtask

	task automatic test_random_traffic(input int target);
		int stop_at;
		int mode;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				program_random();
			end
			mode = $urandom_range(0, 9);
			case (mode)
				7: scan_region(1'b0, 1'b0, 1'b0, 1'b0);
				8: scan_region(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'b0);
				9: scan_region(1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b1);
				default: scan_region(1'b1, 1'b0, 1'b0, 1'b0);
			endcase
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		program_scanner('0, '0, '0, PLEN_W'(1), {16'($urandom), 32'($urandom)});
		tx_idle_en = 1'b0;
		rx_hold_len = HOLD_CYCLES;
		// every byte opens a region and matches at once, so the pipe fills
		for (int i = 0; i < 12; i++)
			send_byte(8'($urandom), 1'b1, 1'b0);
		tx_idle_en = 1'b1;
	endtask

	task automatic test_quiet_traffic();
		wait_idle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		program_random();
		test_random_traffic(QUIET_ITEMS);
	endtask

	initial begin
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (rx_hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result found=%0b address=%h", $time,
					out_item.found, out_item.match_address);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.found !== want.found) begin
					$display("%0t: found expected %0b got %0b", $time,
						want.found, out_item.found);
					errors++;
				end
				if (out_item.match_address !== want.match_address) begin
					$display("%0t: match_address expected %h got %h", $time,
						want.match_address, out_item.match_address);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		scan_model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_cases();
		test_random_traffic(RANDOM_ITEMS);
		test_backpressure();
		test_quiet_traffic();
		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
